@@ src/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned AlignBytes = 4;
  localparam int unsigned ReqW       = 21;
  localparam int unsigned NeedW      = 22;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned PaddrW     = 3;

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_ZERO  = 2'd1,
    ST_NOFIT = 2'd2,
    ST_NULL  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_TAKE,
    S_A_CHK,
    S_A_SPLIT,
    S_F_RD,
    S_F_TAKE,
    S_F_CHK,
    S_C_RD,
    S_C_TAKE,
    S_C_CHK,
    S_C_MRG
  } ctrl_state_e;

  typedef struct packed {
    logic    in_ready;
    logic    start;
    logic    rd_cur;
    logic    rd_nxt;
    logic    take_cur;
    logic    adv;
    logic    off_zero;
    logic    wr_alloc;
    logic    wr_rest;
    logic    wr_mark;
    logic    wr_merge;
    logic    res_set;
    logic    res_grant;
    status_e res_code;
  } cmd_t;

  typedef struct packed {
    logic  in_valid;
    func_e func;
    logic  req_zero;
    logic  rel_null;
    logic  out_busy;
    logic  fit;
    logic  split;
    logic  nxt_end;
    logic  hit;
    logic  rd_free;
    logic  cur_free;
  } sts_t;

endpackage

@@ src/ffha_if.sv @@
// ----------------------------------------------------------------------------
// ffha_req_if / ffha_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [20:0] request_size;
  logic [31:0] release_address;

  modport source (output valid, func, request_size, release_address, input ready);
  modport sink   (input valid, func, request_size, release_address, output ready);
endinterface

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_address;
  logic [1:0]  status;

  modport source (output valid, result_address, status, input ready);
  modport sink   (input valid, result_address, status, output ready);
endinterface

@@ src/ffha_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for allocate, free-mark and coalescing walks of the block chain.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign accept = (state_q == S_IDLE) && !sts_i.out_busy && sts_i.in_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (sts_i.func == FN_ALLOC) begin
            state_d = sts_i.req_zero ? S_IDLE : S_A_RD;
          end else begin
            state_d = sts_i.rel_null ? S_IDLE : S_F_RD;
          end
        end
      end
      S_A_RD:    state_d = S_A_TAKE;
      S_A_TAKE:  state_d = S_A_CHK;
      S_A_CHK: begin
        if (sts_i.fit) begin
          state_d = sts_i.split ? S_A_SPLIT : S_IDLE;
        end else begin
          state_d = sts_i.nxt_end ? S_IDLE : S_A_RD;
        end
      end
      S_A_SPLIT: state_d = S_IDLE;
      S_F_RD:    state_d = S_F_TAKE;
      S_F_TAKE:  state_d = S_F_CHK;
      S_F_CHK: begin
        if (sts_i.hit || sts_i.nxt_end) begin
          state_d = S_C_RD;
        end else begin
          state_d = S_F_RD;
        end
      end
      S_C_RD:    state_d = S_C_TAKE;
      S_C_TAKE:  state_d = S_C_CHK;
      S_C_CHK: begin
        if (sts_i.cur_free && !sts_i.nxt_end) begin
          state_d = S_C_MRG;
        end else begin
          state_d = sts_i.nxt_end ? S_IDLE : S_C_RD;
        end
      end
      // A merge keeps the walk on the same block with its grown size.
      S_C_MRG:   state_d = sts_i.rd_free ? S_C_CHK : S_C_RD;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.res_code = ST_DONE;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = !sts_i.out_busy;
        cmd_o.start    = accept;
        if (accept) begin
          if (sts_i.func == FN_ALLOC && sts_i.req_zero) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = ST_ZERO;
          end else if (sts_i.func == FN_FREE && sts_i.rel_null) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = ST_NULL;
          end
        end
      end
      S_A_RD, S_F_RD, S_C_RD: cmd_o.rd_cur = 1'b1;
      S_A_TAKE, S_F_TAKE, S_C_TAKE: cmd_o.take_cur = 1'b1;
      S_A_CHK: begin
        if (sts_i.fit) begin
          cmd_o.wr_alloc = 1'b1;
          if (!sts_i.split) begin
            cmd_o.res_set   = 1'b1;
            cmd_o.res_grant = 1'b1;
          end
        end else begin
          cmd_o.adv = 1'b1;
          if (sts_i.nxt_end) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = ST_NOFIT;
          end
        end
      end
      S_A_SPLIT: begin
        cmd_o.wr_rest   = 1'b1;
        cmd_o.res_set   = 1'b1;
        cmd_o.res_grant = 1'b1;
      end
      S_F_CHK: begin
        if (sts_i.hit) begin
          cmd_o.wr_mark  = 1'b1;
          cmd_o.off_zero = 1'b1;
        end else if (sts_i.nxt_end) begin
          cmd_o.off_zero = 1'b1;
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      S_C_CHK: begin
        if (sts_i.cur_free && !sts_i.nxt_end) begin
          cmd_o.rd_nxt = 1'b1;
        end else begin
          cmd_o.adv = 1'b1;
          if (sts_i.nxt_end) begin
            cmd_o.res_set = 1'b1;
          end
        end
      end
      S_C_MRG: begin
        if (sts_i.rd_free) begin
          cmd_o.wr_merge = 1'b1;
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ src/ffha_dp.sv @@
// ----------------------------------------------------------------------------
// ffha_dp
// Header store, chain walk registers, fit and merge arithmetic, result register.
// ----------------------------------------------------------------------------
module ffha_dp import ffha_pkg::*; #(
  parameter int unsigned HEAP_BYTES   = 1048576,
  parameter int unsigned HEADER_BYTES = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [AddrW-1:0]   heap_base_i,
  input  logic               in_valid_i,
  input  logic               in_func_i,
  input  logic [ReqW-1:0]    in_size_i,
  input  logic [AddrW-1:0]   in_rel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [AddrW-1:0]   out_addr_o,
  output logic [1:0]         out_status_o
);

  localparam int unsigned SW    = $clog2(HEAP_BYTES);
  localparam int unsigned OW    = SW + 1;
  localparam int unsigned CW    = ((SW + 2) > (NeedW + 2)) ? (SW + 2) : (NeedW + 2);
  localparam int unsigned Slots = HEAP_BYTES / AlignBytes;
  localparam int unsigned SlotW = $clog2(Slots);

  localparam logic [CW-1:0] HdrC  = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] HeapC = CW'(HEAP_BYTES);
  localparam logic [CW-1:0] AlnC  = CW'(AlignBytes);
  localparam logic [SW-1:0] Size0Rst = SW'(HEAP_BYTES - HEADER_BYTES);

  logic [SW:0]       mem [Slots];
  logic [SW:0]       mem_rd_q;
  logic              zsel_q;
  logic [SW-1:0]     size0_q;
  logic              free0_q;

  logic [OW-1:0]     off_q;
  logic [SW-1:0]     cur_size_q;
  logic              cur_free_q;
  logic [NeedW-1:0]  need_q;
  logic [AddrW-1:0]  target_q;

  logic              res_valid_q;
  logic [AddrW-1:0]  res_addr_q;
  logic [1:0]        res_status_q;

  logic [CW-1:0]     off_w, cur_w, need_w, nxt_w, rest_w, rd_size_w;
  logic [SW-1:0]     rd_size;
  logic              rd_free;
  logic              wr_en, wr_free;
  logic [OW-1:0]     wr_off, rd_off;
  logic [SW-1:0]     wr_size;
  logic [SlotW-1:0]  wr_slot, rd_slot;
  logic [NeedW-1:0]  need_d;

  assign rd_size = zsel_q ? size0_q : mem_rd_q[SW:1];
  assign rd_free = zsel_q ? free0_q : mem_rd_q[0];

  assign off_w     = CW'(off_q);
  assign cur_w     = CW'(cur_size_q);
  assign need_w    = CW'(need_q);
  assign rd_size_w = CW'(rd_size);
  assign nxt_w     = off_w + HdrC + cur_w;
  assign rest_w    = off_w + HdrC + need_w;

  // Round the request up to the alignment.
  assign need_d = (NeedW'(in_size_i) + NeedW'(AlignBytes - 1)) & ~NeedW'(AlignBytes - 1);

  always_comb begin
    sts_o          = '0;
    sts_o.in_valid = in_valid_i;
    sts_o.func     = func_e'(in_func_i);
    sts_o.req_zero = (in_size_i == '0);
    sts_o.rel_null = (in_rel_i == '0);
    sts_o.out_busy = res_valid_q;
    sts_o.fit      = cur_free_q && (cur_w >= need_w);
    sts_o.split    = (cur_w >= need_w + HdrC + AlnC) && (rest_w < HeapC);
    sts_o.nxt_end  = (nxt_w >= HeapC);
    sts_o.hit      = (AddrW'(off_q) == target_q);
    sts_o.rd_free  = rd_free;
    sts_o.cur_free = cur_free_q;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_off  = off_q;
    wr_size = cur_size_q;
    wr_free = 1'b1;
    if (cmd_i.wr_alloc) begin
      wr_en   = 1'b1;
      wr_free = 1'b0;
      if (sts_o.split) begin
        wr_size = SW'(need_q);
      end
    end else if (cmd_i.wr_rest) begin
      wr_en   = 1'b1;
      wr_off  = OW'(rest_w);
      wr_size = SW'(cur_w - need_w - HdrC);
    end else if (cmd_i.wr_mark) begin
      wr_en = 1'b1;
    end else if (cmd_i.wr_merge) begin
      wr_en   = 1'b1;
      wr_size = SW'(cur_w + HdrC + rd_size_w);
    end
  end

  assign wr_slot = wr_off[SlotW+1:2];
  assign rd_off  = cmd_i.rd_cur ? off_q : OW'(nxt_w);
  assign rd_slot = rd_off[SlotW+1:2];

  // Entry zero lives in flops so that its reset value holds; the rest is RAM.
  always_ff @(posedge clk_i) begin
    if (wr_en && (wr_slot != '0)) begin
      mem[wr_slot] <= {wr_size, wr_free};
    end
    if (cmd_i.rd_cur || cmd_i.rd_nxt) begin
      mem_rd_q <= mem[rd_slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size0_q <= Size0Rst;
      free0_q <= 1'b1;
      zsel_q  <= 1'b0;
    end else begin
      if (wr_en && (wr_slot == '0)) begin
        size0_q <= wr_size;
        free0_q <= wr_free;
      end
      if (cmd_i.rd_cur || cmd_i.rd_nxt) begin
        zsel_q <= (rd_slot == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      need_q   <= need_d;
      target_q <= in_rel_i - heap_base_i - AddrW'(HEADER_BYTES);
    end
    if (cmd_i.start || cmd_i.off_zero) begin
      off_q <= '0;
    end else if (cmd_i.adv) begin
      off_q <= OW'(nxt_w);
    end
    if (cmd_i.take_cur) begin
      cur_size_q <= rd_size;
      cur_free_q <= rd_free;
    end else if (cmd_i.wr_merge) begin
      cur_size_q <= wr_size;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_code;
      res_addr_q   <= cmd_i.res_grant ?
                      (heap_base_i + AddrW'(off_q) + AddrW'(HEADER_BYTES)) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.res_set) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = res_valid_q;
  assign out_addr_o   = res_addr_q;
  assign out_status_o = res_status_q;

endmodule

@@ src/first_fit_heap_allocator.sv @@
// Each block visited on the chain passes through the read, take and check
// states. Allocate answers when it takes the first fitting block, after a
// further split state if it splits; a zero-size request or a null free answers
// from the idle state. Free walks the chain to find and mark the target, then
// walks it from the start, merging free neighbors. One request is in flight at a time.
// Reset is asynchronous, active low, and leaves one free block over the heap.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap manager with block splitting and free-neighbor coalescing.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int unsigned HEAP_BYTES   = 1048576,
  parameter int unsigned HEADER_BYTES = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ffha_req_if.sink          req_i,
  ffha_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [AddrW-1:0] heap_base_q;
  cmd_t             cmd;
  sts_t             sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? heap_base_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= 32'h0010_0000;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      heap_base_q <= pwdata;
    end
  end

  assign req_i.ready = cmd.in_ready;

  ffha_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .heap_base_i  (heap_base_q),
    .in_valid_i   (req_i.valid),
    .in_func_i    (req_i.func),
    .in_size_i    (req_i.request_size),
    .in_rel_i     (req_i.release_address),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .out_addr_o   (rsp_o.result_address),
    .out_status_o (rsp_o.status)
  );

endmodule
